// ===== rtl/cmt_pkg.sv =====
// package: shared constants, codes and structs of the counting multiset table
`timescale 1ns / 1ps
`default_nettype none

package cmt_pkg;

    // table geometry
    localparam int ENTRIES = 256;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // field widths
    localparam int MODE_W  = 2;
    localparam int KEY_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 16;
    localparam int TOT_W   = 24;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    // search token that walks down the row of cells
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic [CNT_W-1:0] found_cnt;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } pkt_t;

    // slot update broadcast to all cells
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } wr_t;

endpackage

`default_nettype wire

// ===== rtl/cmt_if.sv =====
// interfaces: request and response channels of the counting multiset table
`timescale 1ns / 1ps
`default_nettype none

interface cmt_req_if;
    import cmt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [MODE_W-1:0] mode;
    logic signed [KEY_W-1:0]  key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

interface cmt_rsp_if;
    import cmt_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  occurrences;
    logic [TOT_W-1:0]  total;
    logic              empty_res;

    modport source (output valid, output status, output occurrences, output total,
                    output empty_res, input ready);
    modport sink   (input valid, input status, input occurrences, input total,
                    input empty_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/cmt_cell.sv =====
// cell: one table slot with its match and free check, passes the token on
`timescale 1ns / 1ps
`default_nettype none

module cmt_cell
    import cmt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic [KEY_W-1:0] key,
    input  wire pkt_t             pkt_in,
    input  wire wr_t              wr,
    output pkt_t                  pkt_out
);

    logic [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0] count_reg;
    pkt_t             pkt_reg;
    pkt_t             pkt_next;
    logic             hit;
    logic             is_free;
    logic             sel;

    // local compare against the broadcast key
    assign is_free = (count_reg == '0);
    assign hit     = !is_free && (key_reg == key);
    assign sel     = wr.we && (wr.idx == idx);

    // fold this slot into the token
    always_comb
    begin
        pkt_next = pkt_in;
        if (hit)
        begin
            pkt_next.found     = 1'b1;
            pkt_next.found_idx = idx;
            pkt_next.found_cnt = count_reg;
        end
        if (is_free && !pkt_in.free_found)
        begin
            pkt_next.free_found = 1'b1;
            pkt_next.free_idx   = idx;
        end
        if (!pkt_in.valid)
        begin
            pkt_next = '0;
        end
    end

    // token register toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
        end
    end

    // slot count, zero marks free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (sel)
        begin
            count_reg <= wr.count;
        end
    end

    // slot key, meaningful only while the count is nonzero
    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            key_reg <= wr.key;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

`default_nettype wire

// ===== rtl/counting_multiset_table_unit.sv =====
// top level: counting multiset table built from a row of slot cells
// path: an accepted item's token passes the injection register, each cell's token register
//   and the finished-token register, then commits into the output register when it is free
// one item is searched at a time; the next is taken once the earlier one has committed
// a new item is taken while an earlier result still waits in the output register
// reset: rst_n clears all slot counts, the total and the control flags at once
`timescale 1ns / 1ps
`default_nettype none

module counting_multiset_table_unit
    import cmt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cmt_req_if.sink   req,
    cmt_rsp_if.source rsp
);

    logic              busy_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_reg;
    pkt_t              inj_reg;
    pkt_t              inj_next;
    pkt_t              fin_reg;
    logic [TOT_W-1:0]  total_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [CNT_W-1:0]  occ_reg;
    logic [TOT_W-1:0]  out_total_reg;

    pkt_t              chain [ENTRIES+1];
    wr_t               wr;
    logic              take;
    logic              commit;
    logic [STAT_W-1:0] status_c;
    logic [CNT_W-1:0]  occ_c;
    logic [TOT_W-1:0]  total_c;

    assign req.ready = !busy_reg;
    assign take      = req.valid && req.ready;
    assign commit    = fin_reg.valid && (!out_valid_reg || rsp.ready);

    // token injected in the cycle after an item is taken
    always_comb
    begin
        inj_next       = '0;
        inj_next.valid = take;
    end

    // request capture and token injection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            inj_reg  <= '0;
        end
        else
        begin
            inj_reg <= inj_next;
            if (take)
            begin
                busy_reg <= 1'b1;
            end
            else if (commit)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg <= req.mode;
            key_reg  <= req.key;
        end
    end

    // row of slot cells
    assign chain[0] = inj_reg;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        cmt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (IDX_W'(i)),
            .key     (key_reg),
            .pkt_in  (chain[i]),
            .wr      (wr),
            .pkt_out (chain[i+1])
        );
    end

    // token from the end of the row, held until the output can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= '0;
        end
        else if (chain[ENTRIES].valid)
        begin
            fin_reg <= chain[ENTRIES];
        end
        else if (commit)
        begin
            fin_reg.valid <= 1'b0;
        end
    end

    // operation outcome and slot update
    always_comb
    begin
        status_c = ST_OK;
        occ_c    = '0;
        total_c  = total_reg;
        wr       = '0;
        unique case (mode_reg)
            MODE_ADD:
            begin
                if (fin_reg.found)
                begin
                    occ_c = fin_reg.found_cnt;
                    if (fin_reg.found_cnt == COUNT_MAX || total_reg == TOTAL_MAX)
                    begin
                        status_c = ST_FULL;
                    end
                    else
                    begin
                        occ_c    = fin_reg.found_cnt + CNT_W'(1);
                        total_c  = total_reg + TOT_W'(1);
                        wr.we    = commit;
                        wr.idx   = fin_reg.found_idx;
                        wr.key   = key_reg;
                        wr.count = fin_reg.found_cnt + CNT_W'(1);
                    end
                end
                else if (!fin_reg.free_found || total_reg == TOTAL_MAX)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    occ_c    = CNT_W'(1);
                    total_c  = total_reg + TOT_W'(1);
                    wr.we    = commit;
                    wr.idx   = fin_reg.free_idx;
                    wr.key   = key_reg;
                    wr.count = CNT_W'(1);
                end
            end
            MODE_REMOVE:
            begin
                if (fin_reg.found)
                begin
                    occ_c    = fin_reg.found_cnt - CNT_W'(1);
                    wr.we    = commit;
                    wr.idx   = fin_reg.found_idx;
                    wr.key   = key_reg;
                    wr.count = fin_reg.found_cnt - CNT_W'(1);
                    if (total_reg != '0)
                    begin
                        total_c = total_reg - TOT_W'(1);
                    end
                end
                else
                begin
                    status_c = ST_ABSENT;
                end
            end
            default:
            begin
                // query, and the unused code behaves the same
                if (fin_reg.found)
                begin
                    occ_c = fin_reg.found_cnt;
                end
                else
                begin
                    status_c = ST_ABSENT;
                end
            end
        endcase
    end

    // running total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (commit)
        begin
            total_reg <= total_c;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg    <= status_c;
            occ_reg       <= occ_c;
            out_total_reg <= total_c;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.occurrences = occ_reg;
    assign rsp.total       = out_total_reg;
    assign rsp.empty_res   = (out_total_reg == '0);

`ifndef NO_ASSERTIONS
    // a finished token only exists for an item in flight
    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg.valid |-> busy_reg)
        else $error("finished token without item in flight");

    // the token never reaches the end while an earlier one is still held
    a_end_single: assert property (@(posedge clk) disable iff (!rst_n)
        chain[ENTRIES].valid |-> (busy_reg && !fin_reg.valid))
        else $error("token reached row end unexpectedly");

    // an accepted item injects exactly one token
    a_inject: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (inj_reg.valid && busy_reg))
        else $error("accepted item did not start a search");

    // a commit always presents a result next cycle
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (rsp.valid && !busy_reg))
        else $error("commit did not produce a result");

    // slot writes happen only at commit
    a_write_commit: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |-> (commit && status_c == ST_OK))
        else $error("slot written outside a successful commit");
`endif

endmodule

`default_nettype wire

// ===== test/counting_multiset_table_unit_tb.sv =====
// testbench: random and directed add, remove and query traffic checked against a table predictor
`timescale 1ns / 1ps

module counting_multiset_table_unit_tb;
    import cmt_pkg::*;

    // the mode code that the block treats as a query
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int POOL_N     = 16;
    localparam int FILL_N     = ENTRIES + 14;
    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL       = 2 * (ENTRIES + 3);
    localparam int HOLD_LEN   = 1500;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        bit                drain;
    } op_item_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  occurrences;
        logic [TOT_W-1:0]  total;
        logic              empty_res;
    } tally_t;

    logic clk = 1'b0;
    logic rst_n;

    cmt_req_if op_ch ();
    cmt_rsp_if res_ch ();

    counting_multiset_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (op_ch),
        .rsp   (res_ch)
    );

    // predicted table contents
    logic [KEY_W-1:0] tbl_key [ENTRIES];
    logic [CNT_W-1:0] tbl_cnt [ENTRIES];
    logic [TOT_W-1:0] tbl_total;

    op_item_t         pend_q [$];
    tally_t           tally_q [$];
    logic [KEY_W-1:0] pool [POOL_N];

    bit req_fired;
    int err_cnt;
    int idle_cycles;
    int res_count;

    // sender and receiver pacing
    int burst_left;
    int gap_left;
    int hold_left;
    bit long_done;
    int pat_mode;
    int pat_left;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // apply one item to the predicted table and return the result it should produce
    function automatic tally_t apply_op(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k);
        tally_t r;
        int     hit;
        int     spare;
        hit   = -1;
        spare = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && tbl_cnt[i] != '0 && tbl_key[i] == k)
                hit = i;
            if (spare < 0 && tbl_cnt[i] == '0)
                spare = i;
        end
        r.occurrences = '0;
        case (op)
            MODE_ADD:
            begin
                if (hit >= 0)
                begin
                    r.occurrences = tbl_cnt[hit];
                    if (tbl_cnt[hit] == COUNT_MAX || tbl_total == TOTAL_MAX)
                        r.status = ST_FULL;
                    else
                    begin
                        tbl_cnt[hit]  = tbl_cnt[hit] + 1'b1;
                        tbl_total     = tbl_total + 1'b1;
                        r.occurrences = tbl_cnt[hit];
                        r.status      = ST_OK;
                    end
                end
                else if (spare < 0 || tbl_total == TOTAL_MAX)
                    r.status = ST_FULL;
                else
                begin
                    tbl_key[spare] = k;
                    tbl_cnt[spare] = CNT_W'(1);
                    tbl_total      = tbl_total + 1'b1;
                    r.occurrences  = CNT_W'(1);
                    r.status       = ST_OK;
                end
            end
            MODE_REMOVE:
            begin
                if (hit >= 0)
                begin
                    tbl_cnt[hit]  = tbl_cnt[hit] - 1'b1;
                    r.occurrences = tbl_cnt[hit];
                    if (tbl_total != '0)
                        tbl_total = tbl_total - 1'b1;
                    r.status = ST_OK;
                end
                else
                    r.status = ST_ABSENT;
            end
            default:
            begin
                // query, and the spare code that acts as one
                if (hit >= 0)
                begin
                    r.occurrences = tbl_cnt[hit];
                    r.status      = ST_OK;
                end
                else
                    r.status = ST_ABSENT;
            end
        endcase
        r.total     = tbl_total;
        r.empty_res = (tbl_total == '0);
        return r;
    endfunction

    task automatic queue_op(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k, input bit d);
        op_item_t it;
        it.mode  = m;
        it.key   = k;
        it.drain = d;
        pend_q.push_back(it);
    endtask

    // weighted toward adds so that counts build up
    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return MODE_ADD;
        else if (r < 80)
            return MODE_REMOVE;
        else if (r < 95)
            return MODE_QUERY;
        return MODE_SPARE;
    endfunction

    // mostly keys from the pool, some stray keys that are almost never held
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return pool[$urandom_range(0, POOL_N - 1)];
        return $urandom;
    endfunction

    // check results, predict accepted items, count idle cycles
    always @(posedge clk)
    begin
        tally_t e;
        if (rst_n)
        begin
            req_fired = op_ch.valid && op_ch.ready;
            if (res_ch.valid && res_ch.ready)
            begin
                res_count++;
                if (tally_q.size() == 0)
                begin
                    $error("result with no item outstanding");
                    err_cnt++;
                end
                else
                begin
                    e = tally_q.pop_front();
                    if (res_ch.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, res_ch.status);
                        err_cnt++;
                    end
                    if (res_ch.occurrences !== e.occurrences)
                    begin
                        $error("occurrences: expected %0d, got %0d",
                               e.occurrences, res_ch.occurrences);
                        err_cnt++;
                    end
                    if (res_ch.total !== e.total)
                    begin
                        $error("total: expected %0d, got %0d", e.total, res_ch.total);
                        err_cnt++;
                    end
                    if (res_ch.empty_res !== e.empty_res)
                    begin
                        $error("empty_res: expected %0d, got %0d",
                               e.empty_res, res_ch.empty_res);
                        err_cnt++;
                    end
                end
            end
            if (req_fired)
            begin
                tally_q.push_back(apply_op(op_ch.mode, op_ch.key));
                void'(pend_q.pop_front());
            end
            if (req_fired || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // sender: bursts of items with random gaps, holds valid until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_fired)
            begin
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
                end
            end
            if (op_ch.valid && !req_fired)
            begin
                // item still on offer
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                op_ch.valid <= 1'b0;
            end
            else if (pend_q.size() > 0 && !(pend_q[0].drain && tally_q.size() > 0))
            begin
                op_ch.valid <= 1'b1;
                op_ch.mode  <= pend_q[0].mode;
                op_ch.key   <= pend_q[0].key;
            end
            else
                op_ch.valid <= 1'b0;
        end
    end

    // receiver: changing stall patterns plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!long_done && res_count >= 150)
            begin
                long_done = 1'b1;
                hold_left = HOLD_LEN;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(20, 600);
                end
                else
                    pat_left--;
                case (pat_mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin
        logic [KEY_W-1:0] fresh [FILL_N];
        bit               timed_out;

        rst_n        = 1'b0;
        op_ch.valid  = 1'b0;
        op_ch.mode   = MODE_QUERY;
        op_ch.key    = '0;
        res_ch.ready = 1'b0;
        req_fired    = 1'b0;
        err_cnt      = 0;
        idle_cycles  = 0;
        res_count    = 0;
        burst_left   = 1;
        gap_left     = 0;
        hold_left    = 0;
        long_done    = 1'b0;
        pat_mode     = 0;
        pat_left     = 0;
        timed_out    = 1'b0;
        tbl_total    = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_key[i] = '0;
            tbl_cnt[i] = '0;
        end

        // key pool: the extremes and a few random keys
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_N; i++)
            pool[i] = $urandom;

        // directed: empty table, extreme keys, last occurrence freeing a slot
        queue_op(MODE_QUERY,  32'h0000_0000, 1'b0);
        queue_op(MODE_REMOVE, 32'h8000_0000, 1'b0);
        queue_op(MODE_SPARE,  32'hFFFF_FFFF, 1'b0);
        queue_op(MODE_ADD,    32'h8000_0000, 1'b0);
        queue_op(MODE_ADD,    32'h7FFF_FFFF, 1'b0);
        queue_op(MODE_ADD,    32'h0000_0000, 1'b0);
        queue_op(MODE_ADD,    32'hFFFF_FFFF, 1'b0);
        queue_op(MODE_ADD,    32'h8000_0000, 1'b0);
        queue_op(MODE_QUERY,  32'h8000_0000, 1'b0);
        queue_op(MODE_SPARE,  32'h7FFF_FFFF, 1'b0);
        queue_op(MODE_REMOVE, 32'h8000_0000, 1'b0);
        queue_op(MODE_REMOVE, 32'h8000_0000, 1'b0);
        queue_op(MODE_QUERY,  32'h8000_0000, 1'b0);
        queue_op(MODE_REMOVE, 32'h8000_0000, 1'b0);
        queue_op(MODE_ADD,    32'h5555_5555, 1'b0);
        queue_op(MODE_ADD,    32'hAAAA_AAAA, 1'b0);
        queue_op(MODE_REMOVE, 32'h7FFF_FFFF, 1'b0);
        queue_op(MODE_REMOVE, 32'h0000_0000, 1'b0);
        queue_op(MODE_REMOVE, 32'hFFFF_FFFF, 1'b0);
        queue_op(MODE_REMOVE, 32'h5555_5555, 1'b0);
        queue_op(MODE_REMOVE, 32'hAAAA_AAAA, 1'b0);
        queue_op(MODE_QUERY,  32'h0000_0000, 1'b0);

        // random traffic over the pool
        for (int i = 0; i < 600; i++)
            queue_op(pick_mode(), pick_key(), 1'b0);

        // fill every slot with distinct keys, the first one after a full drain
        for (int i = 0; i < FILL_N; i++)
        begin
            fresh[i] = $urandom;
            queue_op(MODE_ADD, fresh[i], (i == 0));
        end

        // table full: new keys refused, held keys still counted
        for (int i = 0; i < 12; i++)
        begin
            case (i % 3)
                0:       queue_op(MODE_ADD, $urandom, 1'b0);
                1:       queue_op(MODE_ADD, fresh[$urandom_range(0, 40)], 1'b0);
                default: queue_op(MODE_QUERY, fresh[$urandom_range(0, FILL_N - 1)], 1'b0);
            endcase
        end

        // empty the fill again, refused keys come back absent
        for (int i = 0; i < FILL_N; i++)
        begin
            queue_op(MODE_REMOVE, fresh[i], 1'b0);
            if (i % 16 == 15)
                queue_op(MODE_QUERY, fresh[i], 1'b0);
        end

        for (int i = 0; i < 250; i++)
            queue_op(pick_mode(), pick_key(), 1'b0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for all items and results, then a quiet tail
        while (!(pend_q.size() == 0 && tally_q.size() == 0) && idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        if (idle_cycles >= IDLE_LIMIT)
            timed_out = 1'b1;
        else
            repeat (TAIL) @(posedge clk);

        if (err_cnt == 0 && !timed_out && tally_q.size() == 0)
            $display("counting_multiset_table_unit_tb: done, clean");
        else
            $display("counting_multiset_table_unit_tb: done, errors");
        $finish;
    end

endmodule
